FILE: rtl/core/fme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator package
// Shared constants, register indexes and pipeline tag types.
// ----------------------------------------------------------------------------
package fme_pkg;

   localparam int SAMPLE_WIDTH_DEF  = 16;
   localparam int FRACTION_BITS_DEF = 15;
   localparam int CSR_INDEX_WIDTH   = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_SHAPE_MODE = 3'd0,
      REG_POINT_A    = 3'd1,
      REG_POINT_B    = 3'd2,
      REG_POINT_C    = 3'd3,
      REG_POINT_D    = 3'd4
   } fme_reg_type;

   typedef enum logic {
      SHAPE_TRIANGLE  = 1'b0,
      SHAPE_TRAPEZOID = 1'b1
   } fme_shape_type;

   typedef enum logic [1:0] {
      CLS_ZERO  = 2'd0,
      CLS_ONE   = 2'd1,
      CLS_SLOPE = 2'd2
   } fme_cls_type;

   typedef struct packed {
      fme_cls_type cls;
      logic        err;
   } fme_tag_type;

endpackage
`default_nettype wire

FILE: rtl/core/fme_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface fme_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface fme_rsp_if #(parameter int FRACTION_BITS = 15);
   logic                     valid;
   logic                     ready;
   logic [FRACTION_BITS:0]   degree;
   logic                     order_error;

   modport source (output valid, output degree, output order_error, input ready);
   modport sink   (input valid, input degree, input order_error, output ready);
endinterface

interface fme_csr_if #(parameter int INDEX_WIDTH = 3, parameter int DATA_WIDTH = 16);
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] index;
   logic [DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fme_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy membership divider stage
// One restoring division step with its own valid bit and ready chain.
// ----------------------------------------------------------------------------
module fme_div_stage
   import fme_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [SAMPLE_WIDTH-1:0]  in_rem,
   input  wire logic [SAMPLE_WIDTH-1:0]  in_den,
   input  wire logic [FRACTION_BITS-1:0] in_quo,
   input  wire fme_tag_type              in_tag,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [SAMPLE_WIDTH-1:0]       out_rem,
   output logic [SAMPLE_WIDTH-1:0]       out_den,
   output logic [FRACTION_BITS-1:0]      out_quo,
   output fme_tag_type                   out_tag
);

   logic                     valid_ff;
   logic [SAMPLE_WIDTH-1:0]  rem_ff, rem_in;
   logic [SAMPLE_WIDTH-1:0]  den_ff;
   logic [FRACTION_BITS-1:0] quo_ff, quo_in;
   fme_tag_type              tag_ff;
   logic [SAMPLE_WIDTH:0]    shifted;
   logic [SAMPLE_WIDTH+1:0]  diff;
   logic                     fits;

   always_comb begin
      shifted = {in_rem, 1'b0};
      diff    = {1'b0, shifted} - {2'b00, in_den};
      fits    = ~diff[SAMPLE_WIDTH+1];
      rem_in  = fits ? diff[SAMPLE_WIDTH-1:0] : shifted[SAMPLE_WIDTH-1:0];
      quo_in  = {in_quo[FRACTION_BITS-2:0], fits};
   end

   assign in_ready = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_tag   = tag_ff;

endmodule
`default_nettype wire

FILE: rtl/core/fuzzy_membership_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator
// Triangular or trapezoidal membership of a signed sample, Q1.FRACTION_BITS.
// ----------------------------------------------------------------------------
// A sample beat passes the sample, classify and numerator/denominator registers,
// the divider stages (one quotient bit per stage) and the result register.
// Throughput: one beat per cycle unless rsp_ch stalls; every stage has its own
// valid bit, so empty stages keep filling while a result waits at the output.
// Reset clears all valid bits and sets every breakpoint register and the mode
// to zero.
module fuzzy_membership_eval
   import fme_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   fme_req_if.sink   req_ch,
   fme_rsp_if.source rsp_ch,
   fme_csr_if.sink   csr_ch
);

   localparam int W = SAMPLE_WIDTH;
   localparam int F = FRACTION_BITS;

   fme_shape_type       shape_mode_ff;
   logic signed [W-1:0] point_a_ff, point_b_ff, point_c_ff, point_d_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_mode_ff <= SHAPE_TRIANGLE;
         point_a_ff    <= '0;
         point_b_ff    <= '0;
         point_c_ff    <= '0;
         point_d_ff    <= '0;
      end else if (csr_ch.valid) begin
         unique case (fme_reg_type'(csr_ch.index))
            REG_SHAPE_MODE: shape_mode_ff <= fme_shape_type'(csr_ch.data[0]);
            REG_POINT_A:    point_a_ff    <= csr_ch.data;
            REG_POINT_B:    point_b_ff    <= csr_ch.data;
            REG_POINT_C:    point_c_ff    <= csr_ch.data;
            REG_POINT_D:    point_d_ff    <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   logic                s0_valid_ff, s0_ready;
   logic signed [W-1:0] s0_x_ff;

   logic                s1_valid_ff, s1_ready;
   logic signed [W-1:0] s1_x_ff;
   fme_tag_type         s1_tag_ff, s1_tag_in;
   logic                s1_left_ff, s1_left_in;

   logic                s2_valid_ff, s2_ready;
   logic [W-1:0]        s2_num_ff, s2_num_in;
   logic [W-1:0]        s2_den_ff, s2_den_in;
   fme_tag_type         s2_tag_ff;

   logic                div_valid [0:F];
   logic                div_ready [0:F];
   logic [W-1:0]        div_rem   [0:F];
   logic [W-1:0]        div_den   [0:F];
   logic [F-1:0]        div_quo   [0:F];
   fme_tag_type         div_tag   [0:F];

   logic                out_ready;
   logic                rsp_valid_ff;
   logic [F:0]          rsp_degree_ff, rsp_degree_in;
   logic                rsp_err_ff;

   assign s0_ready     = ~s0_valid_ff | s1_ready;
   assign s1_ready     = ~s1_valid_ff | s2_ready;
   assign s2_ready     = div_ready[0];
   assign out_ready    = ~rsp_valid_ff | rsp_ch.ready;
   assign req_ch.ready = s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_ch.valid) begin
         s0_x_ff <= req_ch.sample;
      end
   end

   always_comb begin
      s1_tag_in.err = 1'b0;
      s1_tag_in.cls = CLS_ZERO;
      s1_left_in    = (s0_x_ff < point_b_ff);
      if (shape_mode_ff == SHAPE_TRIANGLE) begin
         if (!(point_a_ff <= point_b_ff && point_b_ff <= point_c_ff)) begin
            s1_tag_in.err = 1'b1;
         end else if (s0_x_ff == point_b_ff) begin
            s1_tag_in.cls = CLS_ONE;
         end else if (s0_x_ff <= point_a_ff || s0_x_ff >= point_c_ff) begin
            s1_tag_in.cls = CLS_ZERO;
         end else begin
            s1_tag_in.cls = CLS_SLOPE;
         end
      end else begin
         if (!(point_a_ff <= point_b_ff && point_b_ff <= point_c_ff &&
               point_c_ff <= point_d_ff)) begin
            s1_tag_in.err = 1'b1;
         end else if (s0_x_ff >= point_b_ff && s0_x_ff <= point_c_ff) begin
            s1_tag_in.cls = CLS_ONE;
         end else if (s0_x_ff < point_a_ff || s0_x_ff >= point_d_ff) begin
            s1_tag_in.cls = CLS_ZERO;
         end else begin
            s1_tag_in.cls = CLS_SLOPE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s0_valid_ff) begin
         s1_x_ff    <= s0_x_ff;
         s1_tag_ff  <= s1_tag_in;
         s1_left_ff <= s1_left_in;
      end
   end

   logic signed [W:0] hi_ext, lo_ext, foot_ext, x_ext, num_ext, den_ext;

   always_comb begin
      x_ext = {s1_x_ff[W-1], s1_x_ff};
      if (s1_left_ff) begin
         hi_ext   = {point_b_ff[W-1], point_b_ff};
         lo_ext   = {point_a_ff[W-1], point_a_ff};
         num_ext  = x_ext - lo_ext;
         foot_ext = lo_ext;
      end else if (shape_mode_ff == SHAPE_TRIANGLE) begin
         hi_ext   = {point_c_ff[W-1], point_c_ff};
         lo_ext   = {point_b_ff[W-1], point_b_ff};
         num_ext  = hi_ext - x_ext;
         foot_ext = lo_ext;
      end else begin
         hi_ext   = {point_d_ff[W-1], point_d_ff};
         lo_ext   = {point_c_ff[W-1], point_c_ff};
         num_ext  = hi_ext - x_ext;
         foot_ext = lo_ext;
      end
      den_ext   = hi_ext - foot_ext;
      s2_num_in = num_ext[W-1:0];
      s2_den_in = den_ext[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_num_ff <= s2_num_in;
         s2_den_ff <= s2_den_in;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   assign div_valid[0] = s2_valid_ff;
   assign div_rem[0]   = s2_num_ff;
   assign div_den[0]   = s2_den_ff;
   assign div_quo[0]   = '0;
   assign div_tag[0]   = s2_tag_ff;
   assign div_ready[F] = out_ready;

   for (genvar k = 0; k < F; k++) begin : g_div
      fme_div_stage #(
         .SAMPLE_WIDTH  (W),
         .FRACTION_BITS (F)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_rem    (div_rem[k]),
         .in_den    (div_den[k]),
         .in_quo    (div_quo[k]),
         .in_tag    (div_tag[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_rem   (div_rem[k+1]),
         .out_den   (div_den[k+1]),
         .out_quo   (div_quo[k+1]),
         .out_tag   (div_tag[k+1])
      );
   end

   always_comb begin
      case (div_tag[F].cls)
         CLS_ONE:   rsp_degree_in = {1'b1, {F{1'b0}}};
         CLS_SLOPE: rsp_degree_in = {1'b0, div_quo[F]};
         default:   rsp_degree_in = '0;
      endcase
      if (div_tag[F].err) begin
         rsp_degree_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_valid[F];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_valid[F]) begin
         rsp_degree_ff <= rsp_degree_in;
         rsp_err_ff    <= div_tag[F].err;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.degree      = rsp_degree_ff;
   assign rsp_ch.order_error = rsp_err_ff;

endmodule
`default_nettype wire
